[design/ffsa_pkg.sv]
package ffsa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SIZE_W       = 17;
  localparam int OFF_W        = 16;

  localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] POOL_LIMIT =
    (ADDR_BITS >= 16) ? SIZE_W'(65536) : SIZE_W'(1 << ADDR_BITS);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MERGE = 2'd2,
    CMD_SPLIT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_NOSEG   = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOTHING = 3'd4
  } status_t;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[design/first_fit_segment_allocator_top.sv]
// First-fit segment allocator. A command transfers at a rising edge with start high and
// busy low; its one result appears on the out_ ports for a single cycle with out_valid
// high and must be taken then, since the block cannot be held off. The segment table
// sits in a single memory read one entry per cycle. A command scans the entries in order
// up to and including the match, then passes a decision state; an alloc or split that
// cuts a segment then moves the entries behind it up one place and writes the remainder,
// and a free or merge that joins two moves the entries behind it down one place, before
// the result is put out. A miss puts out its result right after the scan. An alloc of
// zero size is answered without a scan and without raising busy. After reset and after
// each cfg_wdata write the table is rebuilt while busy is high.
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [OFF_W-1:0]  in_target_offset,
  input  logic [SIZE_W-1:0] in_request_size,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [OFF_W-1:0]  out_seg_offset,
  output logic [SIZE_W-1:0] out_seg_size,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0] pool_r;
  mem_req_t          mreq;
  seg_t              rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        pool_r <= SIZE_W'(1);
      end else if (cfg_wdata > POOL_LIMIT) begin
        pool_r <= POOL_LIMIT;
      end else begin
        pool_r <= cfg_wdata;
      end
    end
  end

  ffsa_seg_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  ffsa_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_command       (in_command),
    .in_target_offset (in_target_offset),
    .in_request_size  (in_request_size),
    .reinit           (cfg_we),
    .pool_size        (pool_r),
    .rdata            (rdata),
    .mreq             (mreq),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_seg_offset   (out_seg_offset),
    .out_seg_size     (out_seg_size)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !(in_command == CMD_ALLOC && in_request_size == '0) |=> busy)
    else $error("accepted command did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOFIT |-> out_seg_offset == '0 && out_seg_size == '0)
    else $error("no-fit result carries a segment");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("table rebuild did not hold off commands");

endmodule

[design/ffsa_seg_ram.sv]
module ffsa_seg_ram
  import ffsa_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output seg_t     rdata
);

  seg_t mem [MAX_SEGMENTS];
  seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/ffsa_ctrl.sv]
module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  input  logic [OFF_W-1:0]  in_target_offset,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic              reinit,
  input  logic [SIZE_W-1:0] pool_size,
  input  seg_t              rdata,
  output mem_req_t          mreq,
  output logic              busy,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [OFF_W-1:0]  out_seg_offset,
  output logic [SIZE_W-1:0] out_seg_size
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SIZE_W-1:0]  acc_r;
  cmd_t               cmd_r;
  logic [OFF_W-1:0]   target_r;
  logic [SIZE_W-1:0]  req_r;
  logic [SIZE_W-1:0]  fsize_r;
  logic               fuse_r;
  logic [SIZE_W-1:0]  new_size_r;
  logic               shift_up_r;
  logic [IDX_W-1:0]   src_r;
  logic [CNT_W-1:0]   left_r;
  logic               wv_r;
  logic [IDX_W-1:0]   wa_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [OFF_W-1:0]   out_off_r;
  logic [SIZE_W-1:0]  out_size_r;

  logic               hit;
  logic               last;
  logic               has_next;
  logic               full;
  logic [SIZE_W-1:0]  sum;
  logic               dec_we;
  seg_t               dec_wdata;
  status_t            dec_status;
  logic [OFF_W-1:0]   dec_off;
  logic [SIZE_W-1:0]  dec_size;
  logic               dec_insert;
  logic               dec_absorb;

  assign last     = ({1'b0, idx_r} + CNT_W'(1)) == count_r;
  assign hit      = (cmd_r == CMD_ALLOC) ? (!rdata.used && rdata.size >= req_r)
                                         : (acc_r == {1'b0, target_r});
  assign has_next = ({1'b0, idx_r} + CNT_W'(1)) < count_r;
  assign full     = count_r >= CNT_W'(MAX_SEGMENTS);
  assign sum      = fsize_r + rdata.size;

  always_comb begin
    dec_we     = 1'b0;
    dec_wdata  = '{used: 1'b0, size: fsize_r};
    dec_status = ST_DONE;
    dec_off    = target_r;
    dec_size   = fsize_r;
    dec_insert = 1'b0;
    dec_absorb = 1'b0;
    case (cmd_r)
      CMD_ALLOC: begin
        dec_off = acc_r[OFF_W-1:0];
        if (fsize_r > req_r) begin
          if (full) begin
            dec_status = ST_FULL;
          end else begin
            dec_we     = 1'b1;
            dec_wdata  = '{used: 1'b1, size: req_r};
            dec_size   = req_r;
            dec_insert = 1'b1;
          end
        end else begin
          dec_we    = 1'b1;
          dec_wdata = '{used: 1'b1, size: fsize_r};
        end
      end
      CMD_FREE: begin
        dec_we     = 1'b1;
        dec_absorb = has_next && !rdata.used;
        if (dec_absorb) begin
          dec_wdata = '{used: 1'b0, size: sum};
          dec_size  = sum;
        end
      end
      CMD_MERGE: begin
        if (!fuse_r && has_next && !rdata.used) begin
          dec_we     = 1'b1;
          dec_absorb = 1'b1;
          dec_wdata  = '{used: 1'b0, size: sum};
          dec_size   = sum;
        end else begin
          dec_status = ST_NOTHING;
        end
      end
      CMD_SPLIT: begin
        if (req_r == '0) begin
          dec_status = ST_NOTHING;
          dec_off    = '0;
          dec_size   = '0;
        end else if (fsize_r <= req_r) begin
          dec_status = ST_NOTHING;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_we     = 1'b1;
          dec_wdata  = '{used: fuse_r, size: req_r};
          dec_size   = req_r;
          dec_insert = 1'b1;
        end
      end
      default: begin
        dec_status = ST_NOTHING;
      end
    endcase
  end

  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = idx_r;
    mreq.wdata = dec_wdata;
    mreq.raddr = '0;
    case (state_r)
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = '0;
        mreq.wdata = '{used: 1'b0, size: pool_size};
      end
      S_SCAN: begin
        mreq.raddr = idx_r + IDX_W'(1);
      end
      S_DECIDE: begin
        mreq.we = dec_we;
      end
      S_SHIFT: begin
        mreq.raddr = src_r;
        mreq.we    = wv_r;
        mreq.waddr = wa_r;
        mreq.wdata = rdata;
      end
      S_FIN: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx_r + IDX_W'(1);
        mreq.wdata = '{used: 1'b0, size: new_size_r};
      end
      default: begin
        mreq.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_W'(1);
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          count_r <= CNT_W'(1);
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd_t'(in_command);
            target_r <= in_target_offset;
            req_r    <= in_request_size;
            idx_r    <= '0;
            acc_r    <= '0;
            if (cmd_t'(in_command) == CMD_ALLOC && in_request_size == '0) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_NOTHING;
              out_off_r    <= '0;
              out_size_r   <= '0;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            fsize_r <= rdata.size;
            fuse_r  <= rdata.used;
            state_r <= S_DECIDE;
          end else if (last) begin
            out_valid_r <= 1'b1;
            out_size_r  <= '0;
            if (cmd_r == CMD_ALLOC) begin
              out_status_r <= ST_NOFIT;
              out_off_r    <= '0;
            end else begin
              out_status_r <= ST_NOSEG;
              out_off_r    <= target_r;
            end
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
            acc_r <= acc_r + rdata.size;
          end
        end
        S_DECIDE: begin
          out_status_r <= dec_status;
          out_off_r    <= dec_off;
          out_size_r   <= dec_size;
          new_size_r   <= fsize_r - req_r;
          wv_r         <= 1'b0;
          if (dec_insert) begin
            count_r    <= count_r + CNT_W'(1);
            shift_up_r <= 1'b1;
            src_r      <= IDX_W'(count_r - CNT_W'(1));
            left_r     <= count_r - CNT_W'(1) - {1'b0, idx_r};
            state_r    <= S_SHIFT;
          end else if (dec_absorb) begin
            count_r    <= count_r - CNT_W'(1);
            shift_up_r <= 1'b0;
            src_r      <= idx_r + IDX_W'(2);
            left_r     <= count_r - CNT_W'(2) - {1'b0, idx_r};
            state_r    <= S_SHIFT;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (left_r != '0) begin
            wv_r   <= 1'b1;
            wa_r   <= shift_up_r ? src_r + IDX_W'(1) : src_r - IDX_W'(1);
            src_r  <= shift_up_r ? src_r - IDX_W'(1) : src_r + IDX_W'(1);
            left_r <= left_r - CNT_W'(1);
          end else begin
            wv_r <= 1'b0;
            if (shift_up_r) begin
              state_r <= S_FIN;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_INIT;
        end
      endcase
      if (reinit) begin
        state_r <= S_INIT;
      end
    end
  end

  assign busy           = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_seg_offset = out_off_r;
  assign out_seg_size   = out_size_r;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ffsa_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 2 * MAX_SEGMENTS + 8;

  typedef struct {
    logic [2:0]        status;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } seg_result_t;

  class segment_tracker;
    logic [SIZE_W-1:0] sizes [MAX_SEGMENTS];
    bit                used [MAX_SEGMENTS];
    int                count;
    int                pool;
    int                errors;
    seg_result_t       expected_results [$];

    function new();
      errors = 0;
      rebuild(POOL_RESET);
    endfunction

    function void rebuild(input int value);
      logic [SIZE_W-1:0] v;
      v = value[SIZE_W-1:0];
      if (v == 0) v = SIZE_W'(1);
      if (v > POOL_LIMIT) v = POOL_LIMIT;
      pool = int'(v);
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        sizes[k] = '0;
        used[k] = 1'b0;
      end
      sizes[0] = v;
      count = 1;
    endfunction

    function int offset_of(input int idx);
      int acc;
      acc = 0;
      for (int k = 0; k < idx && k < count; k++) acc += sizes[k];
      return acc;
    endfunction

    function int index_at(input int off);
      int acc;
      acc = 0;
      for (int k = 0; k < count; k++) begin
        if (acc == off) return k;
        acc += sizes[k];
      end
      return count;
    endfunction

    function void insert_after(input int idx, input int sz);
      for (int k = count; k > idx + 1; k--) begin
        sizes[k] = sizes[k-1];
        used[k] = used[k-1];
      end
      sizes[idx+1] = SIZE_W'(sz);
      used[idx+1] = 1'b0;
      count++;
    endfunction

    function void absorb_next(input int idx);
      sizes[idx] = sizes[idx] + sizes[idx+1];
      for (int k = idx + 1; k + 1 < count; k++) begin
        sizes[k] = sizes[k+1];
        used[k] = used[k+1];
      end
      sizes[count-1] = '0;
      used[count-1] = 1'b0;
      count--;
    endfunction

    function void accept_command(input cmd_t cmd, input int target, input int req);
      seg_result_t r;
      int i;
      r.status = ST_DONE;
      r.offset = '0;
      r.size = '0;
      if (cmd == CMD_ALLOC) begin
        if (req == 0) begin
          r.status = ST_NOTHING;
        end else begin
          for (i = 0; i < count; i++)
            if (!used[i] && sizes[i] >= req) break;
          if (i == count) begin
            r.status = ST_NOFIT;
          end else begin
            r.offset = OFF_W'(offset_of(i));
            if (sizes[i] > req && count >= MAX_SEGMENTS) begin
              r.status = ST_FULL;
              r.size = sizes[i];
            end else begin
              if (sizes[i] > req) begin
                insert_after(i, sizes[i] - req);
                sizes[i] = SIZE_W'(req);
              end
              used[i] = 1'b1;
              r.size = sizes[i];
            end
          end
        end
      end else begin
        i = index_at(target);
        r.offset = OFF_W'(target);
        if (i == count) begin
          r.status = ST_NOSEG;
        end else begin
          case (cmd)
            CMD_FREE: begin
              used[i] = 1'b0;
              if (i + 1 < count && !used[i+1]) absorb_next(i);
            end
            CMD_MERGE: begin
              if (!used[i] && i + 1 < count && !used[i+1]) absorb_next(i);
              else r.status = ST_NOTHING;
            end
            default: begin
              if (req == 0) begin
                r.status = ST_NOTHING;
                r.offset = '0;
              end else if (sizes[i] <= req) begin
                r.status = ST_NOTHING;
              end else if (count >= MAX_SEGMENTS) begin
                r.status = ST_FULL;
              end else begin
                insert_after(i, sizes[i] - req);
                sizes[i] = SIZE_W'(req);
              end
            end
          endcase
          if (!(cmd == CMD_SPLIT && req == 0)) r.size = sizes[i];
        end
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(input logic [2:0] status, input logic [OFF_W-1:0] offset,
                               input logic [SIZE_W-1:0] size);
      seg_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual status %0d offset %0d size %0d",
                 $time, status, offset, size);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, status);
        errors++;
      end
      if (offset !== e.offset) begin
        $display("%0t: offset mismatch, expected %0d, actual %0d", $time, e.offset, offset);
        errors++;
      end
      if (size !== e.size) begin
        $display("%0t: size mismatch, expected %0d, actual %0d", $time, e.size, size);
        errors++;
      end
    endfunction

    function int random_offset();
      return offset_of($urandom_range(0, count - 1));
    endfunction

    function int random_used_offset();
      int picks [$];
      for (int k = 0; k < count; k++)
        if (used[k]) picks.push_back(k);
      if (picks.size() == 0) return random_offset();
      return offset_of(picks[$urandom_range(0, picks.size() - 1)]);
    endfunction

    function int size_at(input int off);
      int i;
      i = index_at(off);
      return (i < count) ? int'(sizes[i]) : 0;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_command = '0;
  logic [OFF_W-1:0]  in_target_offset = '0;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [OFF_W-1:0]  out_seg_offset;
  logic [SIZE_W-1:0] out_seg_size;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  segment_tracker sb;
  int idle_cycles = 0;

  first_fit_segment_allocator_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_target_offset (in_target_offset),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_seg_offset   (out_seg_offset),
    .out_seg_size     (out_seg_size),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_status, out_seg_offset, out_seg_size);
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL first_fit_segment_allocator_top");
      $finish;
    end
  end

  task automatic send_command(input cmd_t cmd, input int target, input int req);
    start <= 1'b1;
    in_command <= cmd;
    in_target_offset <= target[OFF_W-1:0];
    in_request_size <= req[SIZE_W-1:0];
    do @(posedge clk); while (busy !== 1'b0);
    sb.accept_command(cmd, target & 'hFFFF, req & 'h1FFFF);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic write_pool(input int value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[SIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rebuild(value);
  endtask

  task automatic random_command();
    int pick;
    int target;
    int req;
    int cap;
    cmd_t cmd;
    pick = $urandom_range(0, 99);
    cap = sb.pool / 6 + 1;
    target = $urandom_range(0, 65535);
    req = $urandom_range(0, 131071);
    if (pick < 40) begin
      cmd = CMD_ALLOC;
      case ($urandom_range(0, 19))
        0: req = 0;
        1: req = $urandom_range(0, 131071);
        2: req = sb.pool;
        default: req = $urandom_range(1, cap);
      endcase
    end else if (pick < 60) begin
      cmd = CMD_FREE;
      target = sb.random_used_offset();
    end else if (pick < 72) begin
      cmd = CMD_MERGE;
      target = sb.random_offset();
    end else if (pick < 87) begin
      cmd = CMD_SPLIT;
      target = sb.random_offset();
      if ($urandom_range(0, 9) != 0) req = $urandom_range(0, sb.size_at(target));
    end else begin
      cmd = cmd_t'($urandom_range(0, 3));
    end
    send_command(cmd, target, req);
  endtask

  initial begin
    int pool_value;
    int burst_left;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_command(CMD_ALLOC, 0, 0);
    send_command(CMD_ALLOC, 'hFFFF, 100);
    send_command(CMD_ALLOC, 0, 'h10000);
    send_command(CMD_FREE, 5, 0);
    send_command(CMD_MERGE, 0, 0);
    send_command(CMD_SPLIT, 'hFFFF, 7);
    send_command(CMD_SPLIT, 0, 0);
    send_command(CMD_SPLIT, 0, 100);
    send_command(CMD_SPLIT, 0, 40);
    send_command(CMD_FREE, 40, 0);
    send_command(CMD_MERGE, 40, 0);
    // fill the table
    repeat (MAX_SEGMENTS - 2) send_command(CMD_ALLOC, 0, 1);
    send_command(CMD_ALLOC, 0, 2);
    send_command(CMD_SPLIT, 40 + MAX_SEGMENTS - 2, 10);
    send_command(CMD_ALLOC, 0, 1024 - 40 - (MAX_SEGMENTS - 2));

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: pool_value = 1;
        1: pool_value = 'h10000;
        2: pool_value = 0;
        3: pool_value = 'h1FFFF;
        4: pool_value = 1024;
        5: pool_value = $urandom_range(2, 4096);
        6: pool_value = $urandom_range(0, 131071);
        default: pool_value = $urandom_range(16, 300);
      endcase
      write_pool(pool_value);
      burst_left = $urandom_range(1, 6);
      for (int n = 0; n < 85; n++) begin
        if (n == 40) drain_results();
        if (burst_left == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        end
        random_command();
        burst_left--;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("PASS first_fit_segment_allocator_top");
    end else begin
      $display("FAIL first_fit_segment_allocator_top");
    end
    $finish;
  end

endmodule
